>>> design/breakpoint_curve_interpolator_defines.svh
// Assertion macros for the breakpoint curve interpolator.
`ifndef BREAKPOINT_CURVE_INTERPOLATOR_DEFINES_SVH
`define BREAKPOINT_CURVE_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BCI_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bci assertion failed");
`define BCI_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bci assertion failed");
`else
`define BCI_ASSERT_IMP(lbl, pre, post)
`define BCI_ASSERT_NXT(lbl, pre, post)
`endif
`endif

>>> design/bci_pkg.sv
// Shared constants, codes and types of the breakpoint curve interpolator.
package bci_pkg;
    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int LH_W       = CNT_W + 1;
    localparam int DATA_W     = 32;
    localparam int ENTRY_W    = 2 * DATA_W;

    localparam logic [2:0] FN_CLEAR  = 3'd0;
    localparam logic [2:0] FN_INSERT = 3'd1;
    localparam logic [2:0] FN_APPEND = 3'd2;
    localparam logic [2:0] FN_EVAL   = 3'd3;
    localparam logic [2:0] FN_READ   = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_SCAN, ST_SHIFT, ST_WRITE, ST_EV_FIRST, ST_EV_LAST,
        ST_BS_ISSUE, ST_BS_MID, ST_BS_NXT, ST_INTERP, ST_DIV, ST_RD_WAIT, ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        DV_IDLE, DV_MUL, DV_LOAD, DV_RUN, DV_DONE
    } div_state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] divisor;
    } div_req_t;
endpackage

>>> design/bci_ram.sv
// Simple dual-port RAM with registered read data.
module bci_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> design/bci_div.sv
// Multiply then restoring divide: quotient of (mag_a * mag_b) / divisor.
module bci_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bci_pkg::div_req_t             req,
    output logic                          done,
    output logic [bci_pkg::DATA_W-1:0]    quotient
);
    import bci_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    div_state_t            dstate_reg, dstate_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DATA_W-1:0]     a_reg, b_reg, div_reg;
    logic [2*DATA_W-1:0]   prod_reg;
    logic [DATA_W-1:0]     rem_reg, quo_reg;
    logic [DATA_W:0]       trial;
    logic [DATA_W:0]       diff;
    logic                  ge;

    assign trial    = {rem_reg, quo_reg[DATA_W-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign diff     = trial - {1'b0, div_reg};
    assign done     = (dstate_reg == DV_DONE);
    assign quotient = quo_reg;

    always_comb
    begin
        dstate_next = dstate_reg;
        step_next   = step_reg;
        case (dstate_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    dstate_next = DV_MUL;
                end
            end
            DV_MUL:  dstate_next = DV_LOAD;
            DV_LOAD:
            begin
                dstate_next = DV_RUN;
                step_next   = '0;
            end
            DV_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DATA_W - 1))
                begin
                    dstate_next = DV_DONE;
                end
            end
            DV_DONE: dstate_next = DV_IDLE;
            default: dstate_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= DV_IDLE;
            step_reg   <= '0;
        end
        else
        begin
            dstate_reg <= dstate_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dstate_reg == DV_IDLE && req.start)
        begin
            a_reg   <= req.mag_a;
            b_reg   <= req.mag_b;
            div_reg <= req.divisor;
        end
        if (dstate_reg == DV_MUL)
        begin
            prod_reg <= a_reg * b_reg;
        end
        if (dstate_reg == DV_LOAD)
        begin
            // high half is below the divisor, so the quotient fits one word
            rem_reg <= prod_reg[2*DATA_W-1:DATA_W];
            quo_reg <= prod_reg[DATA_W-1:0];
        end
        if (dstate_reg == DV_RUN)
        begin
            rem_reg <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], ge};
        end
    end
endmodule

>>> design/breakpoint_curve_interpolator.sv
// Top level of the breakpoint curve interpolator: sequencer, table RAM and divider.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid in_ready func time_req value     | one request per operation
//          | hold_end index                            |
//  out     | out_valid out_ready out_value out_time    | one result per request
//          | point_total status                        |
//
// Clear and full/out-of-range go from dispatch to the response; append writes and read waits first.
// Sorted insert scans one entry a cycle up to the insertion place, then shifts
// one entry a cycle upward, a pace set by the single RAM port pair.
// Evaluate: binary-search steps (issue, mid and, if the mid time is below the query, next;
// at most log2(count)+1 steps), then multiply and bit-serial divide.
// Reset clears count and sequencer, not the table; a stalled output holds the sequencer.
module breakpoint_curve_interpolator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          func,
    input  logic signed [31:0]  time_req,
    input  logic signed [31:0]  value,
    input  logic                hold_end,
    input  logic [7:0]          index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_value,
    output logic signed [31:0]  out_time,
    output logic [8:0]          point_total,
    output logic [1:0]          status
);
    import bci_pkg::*;
    `include "breakpoint_curve_interpolator_defines.svh"

    // control state
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;

    // request and working registers
    logic [2:0]               func_reg;
    logic signed [DATA_W-1:0] tq_reg, val_reg;
    logic                     hold_reg;
    logic [7:0]               idx_reg;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic signed [LH_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [ADDR_W-1:0]        mid_reg, mid_next;
    logic signed [DATA_W-1:0] t0_reg, t0_next, v0_reg, v0_next;
    logic signed [DATA_W-1:0] t1_reg, t1_next, v1_reg, v1_next;
    logic                     neg_reg, neg_next;
    logic signed [DATA_W-1:0] res_value_reg, res_value_next;
    logic signed [DATA_W-1:0] res_time_reg, res_time_next;
    logic [1:0]               res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] out_value_reg, out_time_reg;
    logic [CNT_W-1:0]         out_total_reg;
    logic [1:0]               out_status_reg;

    // RAM ports
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic [ENTRY_W-1:0]       wr_data, rd_data;
    logic signed [DATA_W-1:0] rd_time, rd_value;

    // interpolation
    logic signed [DATA_W:0]   span, dt, dv;
    logic [DATA_W:0]          dv_mag;
    logic [LH_W-1:0]          lh_sum;
    logic [CNT_W-1:0]         top;
    div_req_t                 div_req;
    logic                     div_done;
    logic [DATA_W-1:0]        div_q;

    assign rd_time  = rd_data[ENTRY_W-1:DATA_W];
    assign rd_value = rd_data[DATA_W-1:0];
    assign top      = count_reg - 1'b1;
    assign lh_sum   = LH_W'(lo_reg + hi_reg);

    assign span   = {t1_reg[DATA_W-1], t1_reg} - {t0_reg[DATA_W-1], t0_reg};
    assign dt     = {tq_reg[DATA_W-1], tq_reg} - {t0_reg[DATA_W-1], t0_reg};
    assign dv     = {v1_reg[DATA_W-1], v1_reg} - {v0_reg[DATA_W-1], v0_reg};
    assign dv_mag = dv[DATA_W] ? (-dv) : dv;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_time    = out_time_reg;
    assign point_total = out_total_reg;
    assign status      = out_status_reg;

    bci_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (MAX_POINTS),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        t0_next         = t0_reg;
        v0_next         = v0_reg;
        t1_next         = t1_reg;
        v1_next         = v1_reg;
        neg_next        = neg_reg;
        res_value_next  = res_value_reg;
        res_time_next   = res_time_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg[ADDR_W-1:0];
        wr_data         = {tq_reg, val_reg};
        rd_addr         = '0;
        div_req         = '0;
        div_req.mag_a   = dv_mag[DATA_W-1:0];
        div_req.mag_b   = dt[DATA_W-1:0];
        div_req.divisor = span[DATA_W-1:0];

        // drop a taken result
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                res_value_next  = '0;
                res_time_next   = '0;
                res_status_next = STAT_OK;
                state_next      = ST_RESP;
                case (func_reg)
                    FN_CLEAR: count_next = '0;
                    FN_INSERT, FN_APPEND:
                    begin
                        if (count_reg == CNT_W'(MAX_POINTS))
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else if (func_reg == FN_APPEND || count_reg == '0)
                        begin
                            pos_next   = count_reg;
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            rd_addr    = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    FN_EVAL:
                    begin
                        if (count_reg != '0)
                        begin
                            rd_addr    = '0;
                            state_next = ST_EV_FIRST;
                        end
                    end
                    FN_READ:
                    begin
                        if (CNT_W'(idx_reg) < count_reg)
                        begin
                            rd_addr    = ADDR_W'(idx_reg);
                            state_next = ST_RD_WAIT;
                        end
                        else
                        begin
                            res_status_next = STAT_RANGE;
                        end
                    end
                    default: state_next = ST_RESP;
                endcase
            end
            ST_SCAN:
            begin
                // first stored time strictly above the new one marks the slot
                if (rd_time > tq_reg)
                begin
                    pos_next   = ptr_reg;
                    ptr_next   = top;
                    rd_addr    = top[ADDR_W-1:0];
                    state_next = ST_SHIFT;
                end
                else if (ptr_reg + 1'b1 == count_reg)
                begin
                    pos_next   = count_reg;
                    state_next = ST_WRITE;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    rd_addr    = ADDR_W'(ptr_reg + 1'b1);
                end
            end
            ST_SHIFT:
            begin
                // copy upward from the top, one entry per cycle
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(ptr_reg + 1'b1);
                wr_data = rd_data;
                if (ptr_reg == pos_reg)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    ptr_next = ptr_reg - 1'b1;
                    rd_addr  = ADDR_W'(ptr_reg - 1'b1);
                end
            end
            ST_WRITE:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = ST_RESP;
            end
            ST_EV_FIRST:
            begin
                if (tq_reg <= rd_time)
                begin
                    if (hold_reg)
                    begin
                        rd_addr    = top[ADDR_W-1:0];
                        state_next = ST_EV_LAST;
                    end
                    else
                    begin
                        res_value_next = rd_value;
                        state_next     = ST_RESP;
                    end
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = LH_W'(top);
                    state_next = ST_BS_ISSUE;
                end
            end
            ST_EV_LAST:
            begin
                res_value_next = rd_value;
                state_next     = ST_RESP;
            end
            ST_BS_ISSUE:
            begin
                if (lo_reg > hi_reg)
                begin
                    // no segment found in an unsorted table: hold the last value
                    rd_addr    = top[ADDR_W-1:0];
                    state_next = ST_EV_LAST;
                end
                else
                begin
                    mid_next   = lh_sum[ADDR_W:1];
                    rd_addr    = lh_sum[ADDR_W:1];
                    state_next = ST_BS_MID;
                end
            end
            ST_BS_MID:
            begin
                t0_next = rd_time;
                v0_next = rd_value;
                if (rd_time < tq_reg)
                begin
                    if (CNT_W'(mid_reg) == top)
                    begin
                        t1_next    = rd_time;
                        v1_next    = rd_value;
                        state_next = ST_INTERP;
                    end
                    else
                    begin
                        rd_addr    = mid_reg + 1'b1;
                        state_next = ST_BS_NXT;
                    end
                end
                else
                begin
                    hi_next    = LH_W'(mid_reg) - 1'b1;
                    state_next = ST_BS_ISSUE;
                end
            end
            ST_BS_NXT:
            begin
                if (rd_time >= tq_reg)
                begin
                    t1_next    = rd_time;
                    v1_next    = rd_value;
                    state_next = ST_INTERP;
                end
                else
                begin
                    lo_next    = LH_W'(mid_reg) + 1'b1;
                    state_next = ST_BS_ISSUE;
                end
            end
            ST_INTERP:
            begin
                neg_next = dv[DATA_W];
                if (span <= 0 || dt <= 0)
                begin
                    res_value_next = v0_reg;
                    state_next     = ST_RESP;
                end
                else if (dt >= span)
                begin
                    res_value_next = v1_reg;
                    state_next     = ST_RESP;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_value_next = neg_reg ? (v0_reg - $signed(div_q))
                                             : (v0_reg + $signed(div_q));
                    state_next     = ST_RESP;
                end
            end
            ST_RD_WAIT:
            begin
                res_value_next = rd_value;
                res_time_next  = rd_time;
                state_next     = ST_RESP;
            end
            ST_RESP:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            tq_reg   <= time_req;
            val_reg  <= value;
            hold_reg <= hold_end;
            idx_reg  <= index;
        end
        ptr_reg        <= ptr_next;
        pos_reg        <= pos_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        t0_reg         <= t0_next;
        v0_reg         <= v0_next;
        t1_reg         <= t1_next;
        v1_reg         <= v1_next;
        neg_reg        <= neg_next;
        res_value_reg  <= res_value_next;
        res_time_reg   <= res_time_next;
        res_status_reg <= res_status_next;
        if (state_reg == ST_RESP && (!out_valid_reg || out_ready))
        begin
            out_value_reg  <= res_value_reg;
            out_time_reg   <= res_time_reg;
            out_total_reg  <= count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    `BCI_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_POINTS))
    `BCI_ASSERT_NXT(a_accept_dispatch, in_valid && in_ready, state_reg == ST_DISPATCH)
    `BCI_ASSERT_IMP(a_write_in_table, wr_en, CNT_W'(wr_addr) <= count_reg)
    `BCI_ASSERT_IMP(a_full_status, out_valid && status == STAT_FULL,
                    point_total == CNT_W'(MAX_POINTS))
endmodule
